// ----- rtl/assert_macros.svh -----
// Concurrent assertion helpers, clocked on clk and quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lcli_pkg.sv -----
package lcli_pkg;

  // quotient magnitude bits beyond the coordinate width
  localparam int unsigned QUOT_HEADROOM = 2;

  // candidate coordinates, each with its own divider lane
  localparam int unsigned NUM_LANES = 4;

  typedef enum logic [1:0] {
    LANE_X1 = 2'd0,
    LANE_X2 = 2'd1,
    LANE_Y1 = 2'd2,
    LANE_Y2 = 2'd3
  } lane_t;

endpackage

// ----- rtl/lookahead_circle_line_intersect.sv -----
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   start, end, robot position, radius
// out_     output     out_valid/out_stall target point, degenerate flag
//
// One item enters per clock while the pipeline is not frozen. Most of the depth
// comes from the bit-per-stage square root (2*COORD_WIDTH+1 stages) followed by the
// bit-per-stage divider lanes (COORD_WIDTH+2 stages).
// rst_n is synchronous, active low, and clears only the stage valid bits.
// The whole pipeline advances together; it freezes only while a result sits in
// the output register and out_stall is high, so in_stall follows that condition.
`include "assert_macros.svh"

module lookahead_circle_line_intersect
  import lcli_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic        [COORD_WIDTH-2:0] in_radius,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_target_x,
  output logic signed [COORD_WIDTH-1:0] out_target_y,
  output logic                          out_degenerate
);

  // Widths. All products are kept exact; magnitudes travel with separate signs.
  localparam int W     = COORD_WIDTH;
  localparam int PW    = W + 1;          // shifted coordinates and deltas
  localparam int H     = PW;             // half width for split multiplies
  localparam int DMW   = 2 * H;          // |D|, determinant
  localparam int LW    = 2 * H;          // L = dx^2 + dy^2
  localparam int RRW   = 2 * W - 2;      // r^2
  localparam int SW    = 2 * W + 1;      // floor(sqrt(disc))
  localparam int DISCW = 2 * SW;         // |r^2 L - D^2|
  localparam int NMW   = 3 * W + 2;      // numerator magnitude
  localparam int NSW   = NMW + 2;        // signed numerator
  localparam int QB    = W + QUOT_HEADROOM; // quotient magnitude bits
  localparam int QW    = QB + 1;         // signed quotient
  localparam int EW    = QW + 1;         // quotient minus segment end
  localparam int SQW   = 2 * EW;
  localparam int DSW   = SQW + 1;

  typedef struct packed {
    logic [PW-1:0] p2x;
    logic [PW-1:0] p2y;
    logic [W-1:0]  cx;
    logic [W-1:0]  cy;
    logic [W-1:0]  sx;
    logic [W-1:0]  sy;
    logic          degen;
  } side_t;

  typedef struct packed {
    side_t          side;
    logic [DMW-1:0] dmag;
    logic           dneg;
    logic [LW-1:0]  l;
    logic [PW-1:0]  dxm;
    logic           dxn;
    logic [PW-1:0]  dym;
    logic           dyn;
  } carry_t;

  // Advance everything unless a finished result is held by the consumer.
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // ---------------------------------------------------------------- stage A
  // Shift the segment so the robot sits at the origin.
  logic                 a_v_r;
  logic signed [PW-1:0] a_dx_nxt, a_dy_nxt, a_p1x_nxt, a_p1y_nxt;
  logic signed [PW-1:0] a_dx_r, a_dy_r, a_p1x_r, a_p1y_r;
  side_t                a_side_nxt, a_side_r;
  logic [W-2:0]         a_r_r;

  always_comb begin
    a_dx_nxt         = PW'(in_end_x) - PW'(in_start_x);
    a_dy_nxt         = PW'(in_end_y) - PW'(in_start_y);
    a_p1x_nxt        = PW'(in_start_x) - PW'(in_pos_x);
    a_p1y_nxt        = PW'(in_start_y) - PW'(in_pos_y);
    a_side_nxt.p2x   = PW'(in_end_x) - PW'(in_pos_x);
    a_side_nxt.p2y   = PW'(in_end_y) - PW'(in_pos_y);
    a_side_nxt.cx    = in_pos_x;
    a_side_nxt.cy    = in_pos_y;
    a_side_nxt.sx    = in_start_x;
    a_side_nxt.sy    = in_start_y;
    a_side_nxt.degen = (in_start_x == in_end_x) && (in_start_y == in_end_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx_r   <= a_dx_nxt;
      a_dy_r   <= a_dy_nxt;
      a_p1x_r  <= a_p1x_nxt;
      a_p1y_r  <= a_p1y_nxt;
      a_side_r <= a_side_nxt;
      a_r_r    <= in_radius;
    end
  end

  // ---------------------------------------------------------------- stage B
  // Cross products for D, squares for L and r^2.
  logic                   b_v_r;
  logic signed [2*PW-1:0] b_m1_nxt, b_m2_nxt, b_m1_r, b_m2_r;
  logic [2*PW-1:0]        b_lx_nxt, b_ly_nxt, b_lx_r, b_ly_r;
  logic [RRW-1:0]         b_rr_nxt, b_rr_r;
  logic signed [PW-1:0]   b_dx_r, b_dy_r;
  side_t                  b_side_r;

  always_comb begin
    b_m1_nxt = a_p1x_r * $signed(a_side_r.p2y);
    b_m2_nxt = $signed(a_side_r.p2x) * a_p1y_r;
    b_lx_nxt = a_dx_r * a_dx_r;
    b_ly_nxt = a_dy_r * a_dy_r;
    b_rr_nxt = a_r_r * a_r_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_m1_r   <= b_m1_nxt;
      b_m2_r   <= b_m2_nxt;
      b_lx_r   <= b_lx_nxt;
      b_ly_r   <= b_ly_nxt;
      b_rr_r   <= b_rr_nxt;
      b_dx_r   <= a_dx_r;
      b_dy_r   <= a_dy_r;
      b_side_r <= a_side_r;
    end
  end

  // ---------------------------------------------------------------- stage C
  // Form D and L; split D, dx and dy into magnitude and sign.
  logic                 c_v_r;
  logic signed [2*PW:0] c_d;
  carry_t               c_c_nxt, c_c_r;
  logic [RRW-1:0]       c_rr_r;

  always_comb begin
    c_d          = (2*PW+1)'(b_m1_r) - (2*PW+1)'(b_m2_r);
    c_c_nxt.side = b_side_r;
    c_c_nxt.dneg = c_d[2*PW];
    c_c_nxt.dmag = c_d[2*PW] ? DMW'(-c_d) : DMW'(c_d);
    c_c_nxt.l    = LW'(b_lx_r + b_ly_r);
    c_c_nxt.dxn  = b_dx_r[PW-1];
    c_c_nxt.dxm  = b_dx_r[PW-1] ? PW'(-b_dx_r) : PW'(b_dx_r);
    c_c_nxt.dyn  = b_dy_r[PW-1];
    c_c_nxt.dym  = b_dy_r[PW-1] ? PW'(-b_dy_r) : PW'(b_dy_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_c_r  <= c_c_nxt;
      c_rr_r <= b_rr_r;
    end
  end

  // ---------------------------------------------------------------- stage E
  // Half-width partial products of r^2 * L and D * D.
  logic            e_v_r;
  logic [2*H-1:0]  e_rr_p;
  logic [2*H-1:0]  e_a_nxt [4];
  logic [2*H-1:0]  e_b_nxt [3];
  logic [2*H-1:0]  e_a_r [4];
  logic [2*H-1:0]  e_b_r [3];
  carry_t          e_c_r;

  always_comb begin
    e_rr_p     = (2*H)'(c_rr_r);
    e_a_nxt[0] = e_rr_p[H-1:0]   * c_c_r.l[H-1:0];
    e_a_nxt[1] = e_rr_p[H-1:0]   * c_c_r.l[2*H-1:H];
    e_a_nxt[2] = e_rr_p[2*H-1:H] * c_c_r.l[H-1:0];
    e_a_nxt[3] = e_rr_p[2*H-1:H] * c_c_r.l[2*H-1:H];
    e_b_nxt[0] = c_c_r.dmag[H-1:0]   * c_c_r.dmag[H-1:0];
    e_b_nxt[1] = c_c_r.dmag[H-1:0]   * c_c_r.dmag[2*H-1:H];
    e_b_nxt[2] = c_c_r.dmag[2*H-1:H] * c_c_r.dmag[2*H-1:H];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_a_r <= e_a_nxt;
      e_b_r <= e_b_nxt;
      e_c_r <= c_c_r;
    end
  end

  // ---------------------------------------------------------------- stage F
  // Sum the partials.
  logic           f_v_r;
  logic [4*H-1:0] f_a_nxt, f_b_nxt, f_a_r, f_b_r;
  carry_t         f_c_r;

  always_comb begin
    f_a_nxt = (4*H)'(e_a_r[0])
            + (((4*H)'(e_a_r[1]) + (4*H)'(e_a_r[2])) << H)
            + ((4*H)'(e_a_r[3]) << (2*H));
    f_b_nxt = (4*H)'(e_b_r[0])
            + ((4*H)'(e_b_r[1]) << (H+1))
            + ((4*H)'(e_b_r[2]) << (2*H));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_a_r <= f_a_nxt;
      f_b_r <= f_b_nxt;
      f_c_r <= e_c_r;
    end
  end

  // ------------------------------------------------------------ square root
  // Stage 0 holds |r^2 L - D^2|; each later stage settles one root bit.
  logic [DISCW-1:0] sq_disc_nxt;
  logic [SW:0]      sq_v_r;
  logic [DISCW-1:0] sq_rad_r  [SW+1];
  logic [SW:0]      sq_rem_r  [SW+1];
  logic [SW-1:0]    sq_root_r [SW+1];
  carry_t           sq_c_r    [SW+1];
  logic [DISCW-1:0] sq_rad_nxt  [SW];
  logic [SW:0]      sq_rem_nxt  [SW];
  logic [SW-1:0]    sq_root_nxt [SW];

  assign sq_disc_nxt = (f_a_r >= f_b_r) ? DISCW'(f_a_r - f_b_r) : DISCW'(f_b_r - f_a_r);

  always_comb begin
    logic [SW+2:0] t;
    logic [SW+2:0] trial;
    logic          ge;
    for (int j = 0; j < SW; j++) begin
      t              = {sq_rem_r[j], sq_rad_r[j][DISCW-1 -: 2]};
      trial          = (SW+3)'({sq_root_r[j], 2'b01});
      ge             = (t >= trial);
      sq_rem_nxt[j]  = ge ? (SW+1)'(t - trial) : (SW+1)'(t);
      sq_root_nxt[j] = {sq_root_r[j][SW-2:0], ge};
      sq_rad_nxt[j]  = {sq_rad_r[j][DISCW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rad_r[0]  <= sq_disc_nxt;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_c_r[0]    <= f_c_r;
      for (int j = 0; j < SW; j++) begin
        sq_rad_r[j+1]  <= sq_rad_nxt[j];
        sq_rem_r[j+1]  <= sq_rem_nxt[j];
        sq_root_r[j+1] <= sq_root_nxt[j];
        sq_c_r[j+1]    <= sq_c_r[j];
      end
    end
  end

  // ---------------------------------------------------------------- stage M
  // Partials of |D||dy|, |D||dx|, |dx|s and |dy|s; index 0 is the low half.
  logic           m_v_r;
  logic [2*H-1:0] m_s_p;
  logic [2*H-1:0] m_dy_nxt [2];
  logic [2*H-1:0] m_dx_nxt [2];
  logic [2*H-1:0] m_sx_nxt [2];
  logic [2*H-1:0] m_sy_nxt [2];
  logic [2*H-1:0] m_dy_r [2];
  logic [2*H-1:0] m_dx_r [2];
  logic [2*H-1:0] m_sx_r [2];
  logic [2*H-1:0] m_sy_r [2];
  carry_t         m_c_r;
  carry_t         m_c_in;

  assign m_c_in = sq_c_r[SW];

  always_comb begin
    m_s_p       = (2*H)'(sq_root_r[SW]);
    m_dy_nxt[0] = m_c_in.dmag[H-1:0]   * m_c_in.dym;
    m_dy_nxt[1] = m_c_in.dmag[2*H-1:H] * m_c_in.dym;
    m_dx_nxt[0] = m_c_in.dmag[H-1:0]   * m_c_in.dxm;
    m_dx_nxt[1] = m_c_in.dmag[2*H-1:H] * m_c_in.dxm;
    m_sx_nxt[0] = m_s_p[H-1:0]   * m_c_in.dxm;
    m_sx_nxt[1] = m_s_p[2*H-1:H] * m_c_in.dxm;
    m_sy_nxt[0] = m_s_p[H-1:0]   * m_c_in.dym;
    m_sy_nxt[1] = m_s_p[2*H-1:H] * m_c_in.dym;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_dy_r <= m_dy_nxt;
      m_dx_r <= m_dx_nxt;
      m_sx_r <= m_sx_nxt;
      m_sy_r <= m_sy_nxt;
      m_c_r  <= m_c_in;
    end
  end

  // ---------------------------------------------------------------- stage N
  logic           n_v_r;
  logic [NMW-1:0] n_tdy_nxt, n_tdx_nxt, n_usx_nxt, n_usy_nxt;
  logic [NMW-1:0] n_tdy_r, n_tdx_r, n_usx_r, n_usy_r;
  carry_t         n_c_r;

  always_comb begin
    n_tdy_nxt = NMW'((3*H)'(m_dy_r[0]) + ((3*H)'(m_dy_r[1]) << H));
    n_tdx_nxt = NMW'((3*H)'(m_dx_r[0]) + ((3*H)'(m_dx_r[1]) << H));
    n_usx_nxt = NMW'((3*H)'(m_sx_r[0]) + ((3*H)'(m_sx_r[1]) << H));
    n_usy_nxt = NMW'((3*H)'(m_sy_r[0]) + ((3*H)'(m_sy_r[1]) << H));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_tdy_r <= n_tdy_nxt;
      n_tdx_r <= n_tdx_nxt;
      n_usx_r <= n_usx_nxt;
      n_usy_r <= n_usy_nxt;
      n_c_r   <= m_c_r;
    end
  end

  // ---------------------------------------------------------------- stage P
  // Signed numerators of both intersection points.
  logic                  p_v_r;
  logic signed [NSW-1:0] p_num_nxt [NUM_LANES];
  logic signed [NSW-1:0] p_num_r   [NUM_LANES];
  carry_t                p_c_r;

  always_comb begin
    logic signed [NSW-1:0] tx;
    logic signed [NSW-1:0] ux;
    logic signed [NSW-1:0] ty;
    logic signed [NSW-1:0] uy;
    tx = $signed(NSW'(n_tdy_r));
    if (n_c_r.dneg ^ n_c_r.dyn) begin
      tx = -tx;
    end
    // sgn(dy) * dx * s: nothing when dy is zero
    ux = $signed(NSW'(n_usx_r));
    if (n_c_r.dym == '0) begin
      ux = '0;
    end else if (n_c_r.dxn ^ n_c_r.dyn) begin
      ux = -ux;
    end
    ty = $signed(NSW'(n_tdx_r));
    if (!(n_c_r.dneg ^ n_c_r.dxn)) begin
      ty = -ty;
    end
    uy = $signed(NSW'(n_usy_r));
    p_num_nxt[LANE_X1] = tx + ux;
    p_num_nxt[LANE_X2] = tx - ux;
    p_num_nxt[LANE_Y1] = ty + uy;
    p_num_nxt[LANE_Y2] = ty - uy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_num_r <= p_num_nxt;
      p_c_r   <= n_c_r;
    end
  end

  // --------------------------------------------------------------- dividers
  // Four restoring lanes; stage 0 loads |numerator|, each later stage adds one
  // quotient bit. The quotient fits in QB bits, so the top part starts below L.
  logic [QB:0]    dv_v_r;
  logic [LW-1:0]  dv_rem_r [QB+1][NUM_LANES];
  logic [QB-1:0]  dv_low_r [QB+1][NUM_LANES];
  logic [QB-1:0]  dv_q_r   [QB+1][NUM_LANES];
  logic           dv_neg_r [QB+1][NUM_LANES];
  carry_t         dv_c_r   [QB+1];
  logic [LW-1:0]  dv_rem0_nxt [NUM_LANES];
  logic [QB-1:0]  dv_low0_nxt [NUM_LANES];
  logic [LW-1:0]  dv_rem_nxt  [QB][NUM_LANES];
  logic [QB-1:0]  dv_low_nxt  [QB][NUM_LANES];
  logic [QB-1:0]  dv_q_nxt    [QB][NUM_LANES];

  always_comb begin
    logic [NMW-1:0] mag;
    for (int k = 0; k < NUM_LANES; k++) begin
      mag = p_num_r[k][NSW-1] ? NMW'(-p_num_r[k]) : NMW'(p_num_r[k]);
      dv_rem0_nxt[k] = LW'(mag[NMW-1:QB]);
      dv_low0_nxt[k] = mag[QB-1:0];
    end
  end

  always_comb begin
    logic [LW:0] t;
    logic        ge;
    for (int j = 0; j < QB; j++) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        t  = {dv_rem_r[j][k], dv_low_r[j][k][QB-1]};
        ge = (t >= {1'b0, dv_c_r[j].l});
        dv_rem_nxt[j][k] = ge ? LW'(t - {1'b0, dv_c_r[j].l}) : LW'(t);
        dv_q_nxt[j][k]   = {dv_q_r[j][k][QB-2:0], ge};
        dv_low_nxt[j][k] = {dv_low_r[j][k][QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_c_r[0] <= p_c_r;
      for (int k = 0; k < NUM_LANES; k++) begin
        dv_rem_r[0][k] <= dv_rem0_nxt[k];
        dv_low_r[0][k] <= dv_low0_nxt[k];
        dv_q_r[0][k]   <= '0;
        dv_neg_r[0][k] <= p_num_r[k][NSW-1];
      end
      for (int j = 0; j < QB; j++) begin
        dv_c_r[j+1] <= dv_c_r[j];
        for (int k = 0; k < NUM_LANES; k++) begin
          dv_rem_r[j+1][k] <= dv_rem_nxt[j][k];
          dv_low_r[j+1][k] <= dv_low_nxt[j][k];
          dv_q_r[j+1][k]   <= dv_q_nxt[j][k];
          dv_neg_r[j+1][k] <= dv_neg_r[j][k];
        end
      end
    end
  end

  // --------------------------------------------------------------- stage X1
  // Apply quotient signs and take offsets from the segment end.
  logic                 x1_v_r;
  logic signed [QW-1:0] x1_q_nxt [NUM_LANES];
  logic signed [EW-1:0] x1_e_nxt [NUM_LANES];
  logic signed [QW-1:0] x1_q_r   [NUM_LANES];
  logic signed [EW-1:0] x1_e_r   [NUM_LANES];
  side_t                x1_side_r;
  side_t                x1_side_in;

  assign x1_side_in = dv_c_r[QB].side;

  always_comb begin
    logic signed [QW-1:0] qs;
    for (int k = 0; k < NUM_LANES; k++) begin
      qs = $signed({1'b0, dv_q_r[QB][k]});
      x1_q_nxt[k] = dv_neg_r[QB][k] ? -qs : qs;
    end
    x1_e_nxt[LANE_X1] = EW'(x1_q_nxt[LANE_X1]) - EW'($signed(x1_side_in.p2x));
    x1_e_nxt[LANE_X2] = EW'(x1_q_nxt[LANE_X2]) - EW'($signed(x1_side_in.p2x));
    x1_e_nxt[LANE_Y1] = EW'(x1_q_nxt[LANE_Y1]) - EW'($signed(x1_side_in.p2y));
    x1_e_nxt[LANE_Y2] = EW'(x1_q_nxt[LANE_Y2]) - EW'($signed(x1_side_in.p2y));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_q_r    <= x1_q_nxt;
      x1_e_r    <= x1_e_nxt;
      x1_side_r <= x1_side_in;
    end
  end

  // --------------------------------------------------------------- stage X2
  logic                 x2_v_r;
  logic [SQW-1:0]       x2_sq_nxt [NUM_LANES];
  logic [SQW-1:0]       x2_sq_r   [NUM_LANES];
  logic signed [QW-1:0] x2_q_r    [NUM_LANES];
  side_t                x2_side_r;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      x2_sq_nxt[k] = x1_e_r[k] * x1_e_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_sq_r   <= x2_sq_nxt;
      x2_q_r    <= x1_q_r;
      x2_side_r <= x1_side_r;
    end
  end

  // --------------------------------------------------------------- stage X3
  // Keep the point nearer the segment end; a tie keeps the first one.
  logic                 x3_v_r;
  logic [DSW-1:0]       x3_d1, x3_d2;
  logic                 x3_pick2;
  logic signed [QW-1:0] x3_rx_r, x3_ry_r;
  side_t                x3_side_r;

  always_comb begin
    x3_d1    = DSW'(x2_sq_r[LANE_X1]) + DSW'(x2_sq_r[LANE_Y1]);
    x3_d2    = DSW'(x2_sq_r[LANE_X2]) + DSW'(x2_sq_r[LANE_Y2]);
    x3_pick2 = (x3_d1 > x3_d2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3_rx_r   <= x3_pick2 ? x2_q_r[LANE_X2] : x2_q_r[LANE_X1];
      x3_ry_r   <= x3_pick2 ? x2_q_r[LANE_Y2] : x2_q_r[LANE_Y1];
      x3_side_r <= x2_side_r;
    end
  end

  // ----------------------------------------------------------------- output
  // Shift back to field coordinates and saturate; a degenerate segment
  // returns its start point.
  logic signed [QW:0]  o_sum_x, o_sum_y;
  logic signed [W-1:0] out_target_x_nxt, out_target_y_nxt;
  logic signed [W-1:0] out_target_x_r, out_target_y_r;
  logic                out_degenerate_r;

  function automatic logic signed [W-1:0] sat_coord(input logic signed [QW:0] v);
    logic [QW-W+1:0] top;
    top = v[QW:W-1];
    if ((&top) || !(|top)) begin
      return v[W-1:0];
    end
    return v[QW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  always_comb begin
    o_sum_x = (QW+1)'(x3_rx_r) + (QW+1)'($signed(x3_side_r.cx));
    o_sum_y = (QW+1)'(x3_ry_r) + (QW+1)'($signed(x3_side_r.cy));
    if (x3_side_r.degen) begin
      out_target_x_nxt = $signed(x3_side_r.sx);
      out_target_y_nxt = $signed(x3_side_r.sy);
    end else begin
      out_target_x_nxt = sat_coord(o_sum_x);
      out_target_y_nxt = sat_coord(o_sum_y);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_target_x_r   <= out_target_x_nxt;
      out_target_y_r   <= out_target_y_nxt;
      out_degenerate_r <= x3_side_r.degen;
    end
  end

  // ------------------------------------------------------------ valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      e_v_r       <= 1'b0;
      f_v_r       <= 1'b0;
      sq_v_r      <= '0;
      m_v_r       <= 1'b0;
      n_v_r       <= 1'b0;
      p_v_r       <= 1'b0;
      dv_v_r      <= '0;
      x1_v_r      <= 1'b0;
      x2_v_r      <= 1'b0;
      x3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_v_r       <= in_valid;
      b_v_r       <= a_v_r;
      c_v_r       <= b_v_r;
      e_v_r       <= c_v_r;
      f_v_r       <= e_v_r;
      sq_v_r      <= {sq_v_r[SW-1:0], f_v_r};
      m_v_r       <= sq_v_r[SW];
      n_v_r       <= m_v_r;
      p_v_r       <= n_v_r;
      dv_v_r      <= {dv_v_r[QB-1:0], p_v_r};
      x1_v_r      <= dv_v_r[QB];
      x2_v_r      <= x1_v_r;
      x3_v_r      <= x2_v_r;
      out_valid_r <= x3_v_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_target_x   = out_target_x_r;
  assign out_target_y   = out_target_y_r;
  assign out_degenerate = out_degenerate_r;

  // ------------------------------------------------------------- assertions
  // square root remainder never exceeds twice the partial root
  `ASSERT_IMPL(a_sqrt_rem, sq_v_r[SW], sq_rem_r[SW] <= {sq_root_r[SW], 1'b0}, "sqrt remainder out of range")

  // a frozen pipeline only happens behind a held result
  `ASSERT_NEXT(a_hold_result, out_valid_r && out_stall, out_valid_r, "held result dropped")

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_dv_chk
    // quotient fits the lane width: the loaded top part starts below L
    `ASSERT_IMPL(a_dv_entry, dv_v_r[0] && !dv_c_r[0].side.degen, dv_rem_r[0][k] < dv_c_r[0].l, "quotient overflows lane")
    // remainder stays below the divisor at the last step
    `ASSERT_IMPL(a_dv_exit, dv_v_r[QB] && !dv_c_r[QB].side.degen, dv_rem_r[QB][k] < dv_c_r[QB].l, "divider remainder out of range")
  end

endmodule
